// File: src/printable_string_scanner_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the printable string scanner
// Shared property wrappers, clocked on i_clk, idle while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef PRINTABLE_STRING_SCANNER_CORE_DEFINES_SVH
`define PRINTABLE_STRING_SCANNER_CORE_DEFINES_SVH

// same-cycle implication
`define PSS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Types and constants shared by the printable string scanner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pss_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TILDE = 8'd126;

    localparam int unsigned LEN_W = 11;

    localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 11'd4;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 11'd1024;

    typedef enum logic [1:0] {
        CFG_MIN_LENGTH   = 2'd0,
        CFG_MAX_LENGTH   = 2'd1,
        CFG_FILE_BASE    = 2'd2,
        CFG_VIRTUAL_BASE = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [LEN_W-1:0] min_length;
        logic [LEN_W-1:0] max_length;
        logic [31:0]      file_base;
        logic [31:0]      virtual_base;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       excluded;
        logic       section_first;
    } t_in_item;

    typedef struct packed {
        logic [31:0]      virtual_address;
        logic [31:0]      file_offset;
        logic [LEN_W-1:0] string_length;
    } t_out_item;

    function automatic logic is_printable(input logic [7:0] c);
        logic r;
        r = (c inside {[CHAR_SPACE:CHAR_TILDE]}) || (c inside {CHAR_TAB, CHAR_LF, CHAR_CR});
        return r;
    endfunction

endpackage

// File: src/pss_fifo.sv
// ----------------------------------------------------------------------------
// pss_fifo
// Small register-based queue, push/full on the write side, pop/empty on read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pss_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: src/pss_front.sv
// ----------------------------------------------------------------------------
// pss_front
// Per-byte run tracker; emits a candidate record when a NUL ends a run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pss_front #(
    parameter int MAX_STRING_LEN = 1024,
    parameter int CAND_W         = 76
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  pss_pkg::t_in_item    i_item,
    output logic                 o_cand_push,
    output logic [CAND_W-1:0]    o_cand_data
);

    import pss_pkg::*;

    localparam int RUN_W = $clog2(MAX_STRING_LEN + 1);

    typedef struct packed {
        logic [31:0]      off;
        logic [RUN_W-1:0] run;
        logic             ex_seen;
        logic [31:0]      last_ex;
    } t_cand;

    logic [31:0]      r_offset, n_offset;
    logic [RUN_W-1:0] r_run, n_run;
    logic             r_ex_seen, n_ex_seen;
    logic [31:0]      r_last_ex, n_last_ex;

    logic [31:0]      off;
    logic [RUN_W-1:0] run_base;
    logic             seen_base;
    logic [31:0]      last_base;
    t_cand            cand;

    // section start restarts offset and run before this byte is counted
    always_comb begin
        off       = i_item.section_first ? '0 : r_offset;
        run_base  = i_item.section_first ? '0 : r_run;
        seen_base = i_item.section_first ? 1'b0 : r_ex_seen;
        last_base = i_item.section_first ? '0 : r_last_ex;
    end

    always_comb begin
        n_offset    = r_offset;
        n_run       = r_run;
        n_ex_seen   = r_ex_seen;
        n_last_ex   = r_last_ex;
        o_cand_push = 1'b0;
        if (i_valid) begin
            n_offset = off + 32'd1;
            if (i_item.data_byte == CHAR_NUL) begin
                o_cand_push = (run_base != '0);
                n_run       = '0;
                n_ex_seen   = 1'b0;
                n_last_ex   = '0;
            end else if (is_printable(i_item.data_byte)) begin
                n_run     = (run_base < RUN_W'(MAX_STRING_LEN)) ? run_base + 1'b1 : run_base;
                n_ex_seen = seen_base;
                n_last_ex = last_base;
                if (i_item.excluded) begin
                    n_ex_seen = 1'b1;
                    n_last_ex = off;
                end
            end else begin
                n_run     = '0;
                n_ex_seen = 1'b0;
                n_last_ex = '0;
            end
        end
    end

    always_comb begin
        cand.off     = off;
        cand.run     = run_base;
        cand.ex_seen = seen_base;
        cand.last_ex = last_base;
        o_cand_data  = CAND_W'(cand);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_run     <= '0;
            r_ex_seen <= 1'b0;
            r_last_ex <= '0;
        end else begin
            r_offset  <= n_offset;
            r_run     <= n_run;
            r_ex_seen <= n_ex_seen;
            r_last_ex <= n_last_ex;
        end
    end

endmodule

// File: src/pss_back.sv
// ----------------------------------------------------------------------------
// pss_back
// Candidate evaluation: length clamp, exclusion check, address formation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pss_back #(
    parameter int MAX_STRING_LEN = 1024,
    parameter int CAND_W         = 76
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pss_pkg::t_cfg        i_cfg,
    input  logic                 i_cand_empty,
    input  logic [CAND_W-1:0]    i_cand_data,
    output logic                 o_cand_pop,
    input  logic                 i_out_full,
    output logic                 o_out_push,
    output pss_pkg::t_out_item   o_out_data
);

    import pss_pkg::*;

    localparam int RUN_W = $clog2(MAX_STRING_LEN + 1);

    typedef struct packed {
        logic [31:0]      off;
        logic [RUN_W-1:0] run;
        logic             ex_seen;
        logic [31:0]      last_ex;
    } t_cand;

    t_cand            cand;
    logic [RUN_W-1:0] lim, len;
    logic [LEN_W-1:0] lo;
    logic [31:0]      ex_gap, start, len32;
    logic             hit, ok, s1_ready;

    logic             r_s1_valid;
    logic             r_s1_ok;
    logic [31:0]      r_s1_start;
    logic [RUN_W-1:0] r_s1_len;

    assign cand = t_cand'(i_cand_data);

    // stage 1: clamp limits, trailing-window length, exclusion window test
    always_comb begin
        if (i_cfg.max_length == '0) begin
            lim = RUN_W'(1);
        end else if (32'(i_cfg.max_length) > 32'(MAX_STRING_LEN)) begin
            lim = RUN_W'(MAX_STRING_LEN);
        end else begin
            lim = RUN_W'(i_cfg.max_length);
        end
        lo     = (i_cfg.min_length == '0) ? LEN_W'(1) : i_cfg.min_length;
        len    = (cand.run < lim) ? cand.run : lim;
        len32  = 32'(len);
        ex_gap = cand.off - cand.last_ex;
        hit    = cand.ex_seen && (ex_gap != '0) && (ex_gap <= len32);
        ok     = (len32 >= 32'(lo)) && !hit;
        start  = cand.off - len32;
    end

    assign s1_ready   = !r_s1_valid || !r_s1_ok || !i_out_full;
    assign o_cand_pop = !i_cand_empty && s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_ok    <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= !i_cand_empty;
            r_s1_ok    <= ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_start <= start;
            r_s1_len   <= len;
        end
    end

    // stage 2: base offsets, straight into the result queue
    assign o_out_push = r_s1_valid && r_s1_ok && !i_out_full;

    always_comb begin
        o_out_data.virtual_address = i_cfg.virtual_base + r_s1_start;
        o_out_data.file_offset     = i_cfg.file_base + r_s1_start;
        o_out_data.string_length   = LEN_W'(32'(r_s1_len));
    end

endmodule

// File: src/printable_string_scanner_core.sv
// A NUL transfer's string passes candidate queue, stage-1 register, result queue.
// Throughput: a byte per cycle in while the candidate queue has room, a result per
// cycle out; a 4-entry candidate and 2-entry result queue decouple front and back.
// Reset: synchronous, active low; clears offset, run state and both queues, and
// loads min_length 4, max_length 1024, bases 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
// printable_string_scanner_core
// Finds NUL-terminated printable runs in a section byte stream and reports them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "printable_string_scanner_core_defines.svh"

module printable_string_scanner_core #(
    parameter int MAX_STRING_LEN = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input queue side
    input  logic                 push,
    output logic                 full,
    input  pss_pkg::t_in_item    i_in_item,
    // result queue side
    output logic                 empty,
    input  logic                 pop,
    output pss_pkg::t_out_item   o_out_item,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  pss_pkg::t_cfg_index  i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    import pss_pkg::*;

    localparam int  RUN_W    = $clog2(MAX_STRING_LEN + 1);
    // candidate record: offset, run length, exclusion flag, last excluded offset
    localparam int  CAND_W   = 65 + RUN_W;
    localparam int  CQ_DEPTH = 4;
    localparam int  OQ_DEPTH = 2;
    // reported lengths survive the 11-bit mask only if the limit fits
    localparam bit  LEN_FITS = (MAX_STRING_LEN < 2048);

    t_cfg               r_cfg;
    logic               in_xfer;

    logic               cand_push, cand_pop, cand_full, cand_empty;
    logic [CAND_W-1:0]  cand_wdata, cand_rdata;

    logic               out_push, out_full;
    t_out_item          out_wdata;
    logic [$bits(t_out_item)-1:0] out_rdata;

    // ------------------------------------------------------------------
    // Configuration registers. Always ready; each write is registered and takes effect the next cycle.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_length   <= MIN_LENGTH_RST;
            r_cfg.max_length   <= MAX_LENGTH_RST;
            r_cfg.file_base    <= '0;
            r_cfg.virtual_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_LENGTH:   r_cfg.min_length   <= i_cfg_data[LEN_W-1:0];
                CFG_MAX_LENGTH:   r_cfg.max_length   <= i_cfg_data[LEN_W-1:0];
                CFG_FILE_BASE:    r_cfg.file_base    <= i_cfg_data;
                CFG_VIRTUAL_BASE: r_cfg.virtual_base <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front: byte tracker. Input stalls only when the candidate queue is
    // full, so a byte is taken every cycle while the back keeps up.
    // ------------------------------------------------------------------
    assign full    = cand_full;
    assign in_xfer = push && !full;

    pss_front #(
        .MAX_STRING_LEN (MAX_STRING_LEN),
        .CAND_W         (CAND_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_xfer),
        .i_item      (i_in_item),
        .o_cand_push (cand_push),
        .o_cand_data (cand_wdata)
    );

    // candidate queue between tracker and evaluator
    pss_fifo #(
        .W     (CAND_W),
        .DEPTH (CQ_DEPTH)
    ) u_cand_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cand_push),
        .i_data  (cand_wdata),
        .o_full  (cand_full),
        .i_pop   (cand_pop),
        .o_data  (cand_rdata),
        .o_empty (cand_empty)
    );

    // ------------------------------------------------------------------
    // Back: clamp, exclusion test, address add; drops rejected candidates.
    // ------------------------------------------------------------------
    pss_back #(
        .MAX_STRING_LEN (MAX_STRING_LEN),
        .CAND_W         (CAND_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cand_empty (cand_empty),
        .i_cand_data  (cand_rdata),
        .o_cand_pop   (cand_pop),
        .i_out_full   (out_full),
        .o_out_push   (out_push),
        .o_out_data   (out_wdata)
    );

    // result queue; its head drives the result ports
    pss_fifo #(
        .W     ($bits(t_out_item)),
        .DEPTH (OQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_wdata),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_rdata),
        .o_empty (empty)
    );

    assign o_out_item = t_out_item'(out_rdata);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PSS_ASSERT_IMPL(a_cand_needs_xfer, cand_push, in_xfer, "candidate without transfer")
    `PSS_ASSERT_IMPL(a_first_no_cand, in_xfer && i_in_item.section_first, !cand_push, "cand at start")
    `PSS_ASSERT_IMPL(a_len_nonzero, !empty && LEN_FITS, o_out_item.string_length != '0, "zero length")
    `PSS_ASSERT_NEXT(a_cand_lands, cand_push && cand_empty, !cand_empty, "candidate lost in queue")

endmodule
